// ----- rtl/core/agts_pkg.sv -----
package agts_pkg;

  localparam int DEF_MAX_TASKS   = 16;
  localparam int DEF_MAX_THREADS = 8;
  localparam int DEF_AGE_BITS    = 16;

  // item modes
  localparam logic [1:0] MODE_TICK    = 2'd0;
  localparam logic [1:0] MODE_CTASK   = 2'd1;
  localparam logic [1:0] MODE_CTHREAD = 2'd2;

  // error codes
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_FULL     = 2'd1;
  localparam logic [1:0] ERR_UNKNOWN  = 2'd2;
  localparam logic [1:0] ERR_NO_RUN   = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic ctask;
    logic cthread;
    logic nop;
    logic tick_init;
    logic task_step;
    logic select;
    logic thread_step;
    logic commit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic task_last;
    logic no_task;
    logic thread_last;
  } stat_t;

endpackage

// ----- rtl/core/agts_ctrl.sv -----
module agts_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [1:0]          mode,
  input  agts_pkg::stat_t     status,
  output agts_pkg::cmd_t      cmd,
  output logic                busy
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_TASKS   = 3'd1;
  localparam logic [2:0] S_SELECT  = 3'd2;
  localparam logic [2:0] S_THREADS = 3'd3;
  localparam logic [2:0] S_COMMIT  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (mode)
            agts_pkg::MODE_TICK: begin
              cmd.tick_init = 1'b1;
              state_next    = S_TASKS;
            end
            agts_pkg::MODE_CTASK:   cmd.ctask   = 1'b1;
            agts_pkg::MODE_CTHREAD: cmd.cthread = 1'b1;
            default:                cmd.nop     = 1'b1;
          endcase
        end
      end
      S_TASKS: begin
        cmd.task_step = 1'b1;
        if (status.task_last) state_next = S_SELECT;
      end
      S_SELECT: begin
        cmd.select = 1'b1;
        state_next = status.no_task ? S_IDLE : S_THREADS;
      end
      S_THREADS: begin
        cmd.thread_step = 1'b1;
        if (status.thread_last) state_next = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

// ----- rtl/core/agts_dp.sv -----
module agts_dp #(
  parameter int MAX_TASKS   = agts_pkg::DEF_MAX_TASKS,
  parameter int MAX_THREADS = agts_pkg::DEF_MAX_THREADS,
  parameter int AGE_BITS    = agts_pkg::DEF_AGE_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  agts_pkg::cmd_t     cmd,
  input  logic signed [4:0]  task_ref,
  output agts_pkg::stat_t    status,
  output logic               done,
  output logic               ok,
  output logic [3:0]         new_id,
  output logic signed [4:0]  picked_task,
  output logic signed [3:0]  picked_thread,
  output logic [1:0]         error_code
);

  localparam int TW       = $clog2(MAX_TASKS);
  localparam int HW       = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
  localparam int TH_DEPTH = MAX_TASKS << HW;
  localparam int AW       = TW + HW;
  localparam logic [TW:0]   NT_CNT  = (TW+1)'(MAX_TASKS);
  localparam logic [TW-1:0] NT_LAST = TW'(MAX_TASKS - 1);
  localparam logic [HW:0]   NH_CNT  = (HW+1)'(MAX_THREADS);

  function automatic logic [AGE_BITS-1:0] age_up(input logic [AGE_BITS-1:0] a);
    age_up = (a == {AGE_BITS{1'b1}}) ? a : a + 1'b1;
  endfunction

  logic [MAX_TASKS-1:0]  task_present;
  logic [AGE_BITS-1:0]   task_age [MAX_TASKS];
  logic [TH_DEPTH-1:0]   thread_present;
  logic [AGE_BITS-1:0]   thread_age [TH_DEPTH];
  logic [AGE_BITS-1:0]   rdata;
  logic [TW:0]           next_slot;
  logic                  cur_valid;
  logic [TW-1:0]         cur_task;
  logic [HW-1:0]         cur_thread;
  logic [TW-1:0]         tcnt;
  logic [HW:0]           hcnt;
  logic                  pvalid;
  logic [HW-1:0]         pidx;
  logic                  best_valid;
  logic [AGE_BITS-1:0]   best;
  logic [TW-1:0]         best_task;
  logic [HW-1:0]         best_thread;
  logic [TW-1:0]         sel_task;

  logic [AGE_BITS-1:0]   task_aged;
  logic                  task_cand;
  logic [AW-1:0]         th_addr;
  logic [AGE_BITS-1:0]   th_aged;
  logic                  th_live;
  logic                  th_cand;
  logic                  ref_ok;
  logic [TW-1:0]         ref_idx;
  logic                  free_found;
  logic [HW-1:0]         free_idx;
  logic                  slot_full;
  logic                  pick_ok;
  logic                  mem_we;
  logic [AW-1:0]         mem_wa;
  logic [AGE_BITS-1:0]   mem_wd;
  logic [4:0]            cur_task_out;
  logic [3:0]            cur_thread_out;

  // task scan
  assign task_aged = age_up(task_age[tcnt]);
  assign task_cand = task_present[tcnt] && !(cur_valid && cur_task == tcnt) &&
                     (!best_valid || task_aged > best);

  // thread scan, one stage behind the read
  assign th_addr = {sel_task, pidx};
  assign th_aged = age_up(rdata);
  assign th_live = pvalid && thread_present[th_addr];
  assign th_cand = th_live &&
                   !(cur_valid && cur_task == sel_task && cur_thread == pidx) &&
                   (!best_valid || th_aged > best);

  // create decode
  assign ref_idx   = TW'(task_ref[3:0]);
  assign ref_ok    = !task_ref[4] && (32'(task_ref[3:0]) < MAX_TASKS) &&
                     task_present[ref_idx];
  assign slot_full = (next_slot == NT_CNT);
  assign pick_ok   = best_valid;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int h = MAX_THREADS - 1; h >= 0; h--) begin
      if (!thread_present[{ref_idx, HW'(h)}]) begin
        free_found = 1'b1;
        free_idx   = HW'(h);
      end
    end
  end

  assign status.task_last   = (tcnt == NT_LAST);
  assign status.no_task     = !best_valid && !cur_valid;
  assign status.thread_last = (hcnt == NH_CNT);

  assign cur_task_out   = cur_valid ? 5'(cur_task) : 5'h1f;
  assign cur_thread_out = cur_valid ? 4'(cur_thread) : 4'hf;

  // age memory write port
  always_comb begin
    mem_we = 1'b0;
    mem_wa = th_addr;
    mem_wd = th_aged;
    if (cmd.cthread && ref_ok && free_found) begin
      mem_we = 1'b1;
      mem_wa = {ref_idx, free_idx};
      mem_wd = '0;
    end else if (cmd.thread_step && th_live) begin
      mem_we = 1'b1;
    end else if (cmd.commit && pick_ok) begin
      mem_we = 1'b1;
      mem_wa = {sel_task, best_thread};
      mem_wd = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) thread_age[mem_wa] <= mem_wd;
    rdata <= thread_age[{sel_task, hcnt[HW-1:0]}];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      task_present   <= '0;
      thread_present <= '0;
      next_slot      <= '0;
      cur_valid      <= 1'b0;
      tcnt           <= '0;
      hcnt           <= '0;
      pvalid         <= 1'b0;
      best_valid     <= 1'b0;
      done           <= 1'b0;
    end else begin
      done <= cmd.ctask || cmd.cthread || cmd.nop || cmd.commit ||
              (cmd.select && status.no_task);
      if (cmd.ctask && !slot_full) begin
        task_present[next_slot[TW-1:0]] <= 1'b1;
        next_slot <= next_slot + 1'b1;
      end
      if (cmd.cthread && ref_ok && free_found) begin
        thread_present[{ref_idx, free_idx}] <= 1'b1;
      end
      if (cmd.tick_init) begin
        tcnt       <= '0;
        best_valid <= 1'b0;
      end
      if (cmd.task_step) begin
        tcnt <= tcnt + 1'b1;
        if (task_cand) best_valid <= 1'b1;
      end
      if (cmd.select) begin
        hcnt       <= '0;
        pvalid     <= 1'b0;
        best_valid <= 1'b0;
      end
      if (cmd.thread_step) begin
        hcnt   <= hcnt + 1'b1;
        pvalid <= (hcnt < NH_CNT);
        if (th_cand) best_valid <= 1'b1;
      end
      if (cmd.commit && pick_ok) cur_valid <= 1'b1;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.ctask && !slot_full) task_age[next_slot[TW-1:0]] <= '0;
    if (cmd.task_step && task_present[tcnt]) task_age[tcnt] <= task_aged;
    if (cmd.commit && pick_ok) task_age[sel_task] <= '0;

    if (cmd.task_step && task_cand) begin
      best      <= task_aged;
      best_task <= tcnt;
    end
    if (cmd.thread_step && th_cand) begin
      best        <= th_aged;
      best_thread <= pidx;
    end
    if (cmd.thread_step) pidx <= hcnt[HW-1:0];
    if (cmd.select) sel_task <= best_valid ? best_task : cur_task;
    if (cmd.commit && pick_ok) begin
      cur_task   <= sel_task;
      cur_thread <= best_thread;
    end

    if (cmd.ctask) begin
      ok            <= !slot_full;
      new_id        <= slot_full ? 4'd0 : 4'(next_slot[TW-1:0]);
      error_code    <= slot_full ? agts_pkg::ERR_FULL : agts_pkg::ERR_NONE;
      picked_task   <= $signed(cur_task_out);
      picked_thread <= $signed(cur_thread_out);
    end else if (cmd.cthread) begin
      ok            <= ref_ok && free_found;
      new_id        <= (ref_ok && free_found) ? 4'(free_idx) : 4'd0;
      error_code    <= !ref_ok ? agts_pkg::ERR_UNKNOWN :
                       (free_found ? agts_pkg::ERR_NONE : agts_pkg::ERR_FULL);
      picked_task   <= $signed(cur_task_out);
      picked_thread <= $signed(cur_thread_out);
    end else if (cmd.nop) begin
      ok            <= 1'b0;
      new_id        <= 4'd0;
      error_code    <= agts_pkg::ERR_NONE;
      picked_task   <= $signed(cur_task_out);
      picked_thread <= $signed(cur_thread_out);
    end else if (cmd.select || cmd.commit) begin
      ok            <= cmd.commit && pick_ok;
      new_id        <= 4'd0;
      error_code    <= (cmd.commit && pick_ok) ? agts_pkg::ERR_NONE : agts_pkg::ERR_NO_RUN;
      picked_task   <= (cmd.commit && pick_ok) ? $signed(5'(sel_task)) :
                       $signed(cur_task_out);
      picked_thread <= (cmd.commit && pick_ok) ? $signed(4'(best_thread)) :
                       $signed(cur_thread_out);
    end
  end

endmodule

// ----- rtl/core/aging_task_thread_scheduler.sv -----
// channel  | signals                                          | transfer when
// ---------+--------------------------------------------------+------------------------
// command  | start, busy, mode, task_ref                      | start && !busy at clk
// result   | done, ok, new_id, picked_task, picked_thread,    | done high, one cycle
//          | error_code                                       |
//
// create task, create thread and unknown modes: result shows the cycle after the transfer
// tick: result follows the one-task-per-cycle age walk, selection, the one-thread-per-cycle
//   registered-read age walk and commit
// tick with no task waiting and none running: result follows the task age walk and selection
// busy drops in the cycle the result shows; rst is synchronous, clears the presence tables
// results cannot be stalled: done is a one-cycle strobe
module aging_task_thread_scheduler #(
  parameter int MAX_TASKS   = agts_pkg::DEF_MAX_TASKS,
  parameter int MAX_THREADS = agts_pkg::DEF_MAX_THREADS,
  parameter int AGE_BITS    = agts_pkg::DEF_AGE_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        mode,
  input  logic signed [4:0] task_ref,
  output logic              done,
  output logic              ok,
  output logic [3:0]        new_id,
  output logic signed [4:0] picked_task,
  output logic signed [3:0] picked_thread,
  output logic [1:0]        error_code
);

  // command and status between sequencer and datapath
  agts_pkg::cmd_t  cmd;
  agts_pkg::stat_t status;

  // sequencer: idle, task age walk, selection, thread age walk, commit
  agts_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .mode   (mode),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // datapath: task table, thread presence, thread age memory, result register
  agts_dp #(
    .MAX_TASKS   (MAX_TASKS),
    .MAX_THREADS (MAX_THREADS),
    .AGE_BITS    (AGE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .task_ref      (task_ref),
    .status        (status),
    .done          (done),
    .ok            (ok),
    .new_id        (new_id),
    .picked_task   (picked_task),
    .picked_thread (picked_thread),
    .error_code    (error_code)
  );

endmodule

// ----- rtl/core/agts_checker.sv -----
module agts_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic [1:0]        mode,
  input logic              done,
  input logic              ok,
  input logic [1:0]        error_code
);

  // results only come out when the sequencer is back at rest
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  // a success never carries an error code
  a_ok_clean: assert property (@(posedge clk) disable iff (rst)
    (done && ok) |-> (error_code == agts_pkg::ERR_NONE))
    else $error("ok with error code");

  // every non-tick command answers in the next cycle
  a_fast_cmd: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (mode != agts_pkg::MODE_TICK)) |=> done)
    else $error("create result missing");

  // a tick never answers in the next cycle
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (mode == agts_pkg::MODE_TICK)) |=> (busy && !done))
    else $error("tick did not start walk");

endmodule

bind aging_task_thread_scheduler agts_checker u_agts_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .mode       (mode),
  .done       (done),
  .ok         (ok),
  .error_code (error_code)
);
